### sv/binary_to_decimal_ascii_macros.svh
// Assertion macros of the binary to decimal ASCII converter, used by b2d_emit.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define B2D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2d assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define B2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2d assertion failed");

`else

`define B2D_ASSERT_NOW(label, ante, cons)
`define B2D_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/b2d_pkg.sv
// Shared constants and helper functions of the binary to decimal ASCII converter.
package b2d_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int DIGIT_BITS     = 4;
  localparam int CHAR_BITS      = 6;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE = 6'd57;
  localparam logic [DIGIT_BITS-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ  = 4'd3;

  // Number of decimal digits in the largest value of the given bit width
  function automatic int bcd_digits(input int bits);
    longint unsigned m;
    int n;
    m = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != 64'd0) begin
        m = m / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Add three to a BCD digit of five or more ahead of a left shift
  function automatic logic [DIGIT_BITS-1:0] dabble_adj(input logic [DIGIT_BITS-1:0] d);
    return (d >= DIGIT_FIVE) ? d + DIGIT_ADJ : d;
  endfunction

endpackage

### sv/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
//
// Usage: present a non-negative number on in_value with in_valid; it is taken
// at a rising edge where in_valid is high and in_stall is low. The block
// answers with the decimal digits as ASCII codes on out_digit_char, most
// significant first, leading zeros dropped, one item per digit; out_last
// marks the final digit. Zero gives the single character '0'.
// Timing: the converter shifts one input bit a cycle and then holds its BCD
// result until the emitter takes it. The emitter skips the leading zero
// digits, then sends one digit a cycle while out_stall is low. The converter
// can take a new number as soon as the emitter has taken its result, while
// the emitter still drains it, so the bit-serial shift loop sets the
// throughput.
// Reset (rst_n low, synchronous) empties both stages and the output register.
// A stall on out_stall holds the current digit; the emitter stops in its send
// state and, once its result waits, so does the converter, with in_stall high.
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [VALUE_BITS-1:0]          in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [b2d_pkg::CHAR_BITS-1:0]  out_digit_char,
  output logic                           out_last
);
  import b2d_pkg::*;

  localparam int NDIG = bcd_digits(VALUE_BITS);

  logic                        conv_done;
  logic                        emit_ready;
  logic [NDIG*DIGIT_BITS-1:0]  conv_bcd;

  // Convert binary to BCD one bit a cycle
  b2d_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .done     (conv_done),
    .take     (emit_ready),
    .bcd      (conv_bcd)
  );

  // Send the digits as ASCII one a cycle while out_stall is low
  b2d_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (conv_done),
    .load_ready     (emit_ready),
    .bcd            (conv_bcd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

### sv/b2d_dabble.sv
// Bit-serial shift-and-add-three converter from binary to packed BCD.
module b2d_dabble #(
  parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
  parameter int NDIG       = b2d_pkg::bcd_digits(b2d_pkg::VALUE_BITS_DEF)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [VALUE_BITS-1:0]                in_value,
  output logic                                 done,
  input  logic                                 take,
  output logic [NDIG*b2d_pkg::DIGIT_BITS-1:0]  bcd
);
  import b2d_pkg::*;

  localparam int BCD_W = NDIG * DIGIT_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_DONE  = 3'b100
  } dab_state_t;

  dab_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [BCD_W-1:0]        bcd_adj;

  // Correct every digit on its own before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = dabble_adj(bcd_r[i*DIGIT_BITS +: DIGIT_BITS]);
    end
  end

  // Load, shift one bit a cycle, then hold the result until the emitter takes it
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS - 1);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign done     = (state_r == S_DONE);
  assign bcd      = bcd_r;

endmodule

### sv/b2d_emit.sv
// Digit shifter: drops leading zeros and sends one ASCII digit a cycle unless stalled.
`include "binary_to_decimal_ascii_macros.svh"

module b2d_emit #(
  parameter int NDIG = b2d_pkg::bcd_digits(b2d_pkg::VALUE_BITS_DEF)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load_valid,
  output logic                                 load_ready,
  input  logic [NDIG*b2d_pkg::DIGIT_BITS-1:0]  bcd,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [b2d_pkg::CHAR_BITS-1:0]        out_digit_char,
  output logic                                 out_last
);
  import b2d_pkg::*;

  localparam int BCD_W = NDIG * DIGIT_BITS;
  localparam int POS_W = $clog2(NDIG);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SKIP = 3'b010,
    E_SEND = 3'b100
  } emit_state_t;

  emit_state_t             state_r, state_nxt;
  logic [BCD_W-1:0]        dig_r, dig_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]    char_r, char_nxt;
  logic                    last_r, last_nxt;
  logic [DIGIT_BITS-1:0]   top;
  logic                    out_free;
  logic                    bcd_ok;

  assign top      = dig_r[BCD_W-1 -: DIGIT_BITS];
  assign out_free = !out_valid_r || !out_stall;

  // Skip leading zeros, then move digits into the output register
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    last_nxt      = last_r;
    unique case (state_r)
      E_IDLE: begin
        if (load_valid) begin
          dig_nxt   = bcd;
          pos_nxt   = POS_W'(NDIG - 1);
          state_nxt = E_SKIP;
        end
      end
      E_SKIP: begin
        if (top == '0 && pos_r != '0) begin
          dig_nxt = {dig_r[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
          pos_nxt = pos_r - 1'b1;
        end else begin
          state_nxt = E_SEND;
        end
      end
      E_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top};
          last_nxt      = (pos_r == '0);
          dig_nxt       = {dig_r[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
          pos_nxt       = pos_r - 1'b1;
          if (pos_r == '0) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r  <= dig_nxt;
    pos_r  <= pos_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign load_ready     = (state_r == E_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = char_r;
  assign out_last       = last_r;

  // Check that every handed-over BCD digit is a proper decimal digit
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] > DIGIT_NINE) begin
        bcd_ok = 1'b0;
      end
    end
  end

  `B2D_ASSERT_NOW(a_bcd_digits_valid, load_valid && load_ready, bcd_ok)
  `B2D_ASSERT_NOW(a_char_in_range, out_valid_r, char_r >= ASCII_ZERO && char_r <= ASCII_NINE)
  `B2D_ASSERT_NOW(a_pending_digits, out_valid_r && !last_r, state_r == E_SEND)

endmodule
